/* rtl/text_console_char_engine_defines.svh */
// Shared assertion macros for the text console engine.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH

// Condition must hold on every clock edge out of reset.
`define TCCE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tcce assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define TCCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcce assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcce assertion failed");

`endif

/* rtl/tcce_pkg.sv */
`timescale 1ns / 1ps

package tcce_pkg;

    // Screen geometry
    localparam int NUM_COLUMNS = 80;
    localparam int NUM_ROWS    = 25;
    localparam int TAB_STEP    = 8;
    localparam int CELLS       = NUM_COLUMNS * NUM_ROWS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int REQ_W  = 3;
    localparam int CELL_W = 16;

    // Screen store
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;

    // Fill values
    localparam logic [CELL_W-1:0] BLANK_SCROLL = 16'h0720;
    localparam logic [CELL_W-1:0] BLANK_CLEAR  = 16'h0F20;
    localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h07;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_CHAR    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_MOVE    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RESTORE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    // Classified operation
    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_CR,
        OP_BS,
        OP_TAB,
        OP_MOVE,
        OP_RESTORE,
        OP_CLEAR,
        OP_READ
    } t_op;

    // Item as it travels from front to back
    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              in_range;
        logic              publish;
    } t_item;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ
    } t_back_state;

    localparam int TAB_STOPS = (2 ** COL_W) / TAB_STEP + 1;

    // Next tab stop strictly above column c
    function automatic logic [COL_W:0] tab_stop(input logic [COL_W-1:0] c);
        logic [COL_W:0] stop;
        stop = '0;
        for (int k = TAB_STOPS; k >= 1; k--) begin
            if ((COL_W+1)'(k * TAB_STEP) > {1'b0, c}) begin
                stop = (COL_W+1)'(k * TAB_STEP);
            end
        end
        return stop;
    endfunction

endpackage

/* rtl/tcce_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tcce_front.sv */
`timescale 1ns / 1ps

// Input stage: takes a transaction, decodes it into an operation and holds it
module tcce_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tcce_pkg::REQ_W-1:0]   i_req_type,
    input  logic [tcce_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcce_pkg::COL_W-1:0]   i_col,
    input  logic [tcce_pkg::ROW_W-1:0]   i_row,
    input  logic                         i_last,
    output logic                         o_item_valid,
    output tcce_pkg::t_item              o_item,
    input  logic                         i_item_ready
);

    logic            r_valid;
    tcce_pkg::t_item r_item;
    tcce_pkg::t_item n_item;
    logic            accept;

    // Stage is free when empty or draining into the queue this cycle
    assign o_ready = !r_valid || i_item_ready;
    assign accept  = i_valid && o_ready;

    // Decode request kind and control characters
    always_comb begin
        n_item.code     = i_char_code;
        n_item.col      = i_col;
        n_item.row      = i_row;
        n_item.in_range = (i_col < tcce_pkg::COL_W'(tcce_pkg::NUM_COLUMNS))
                          && (i_row < tcce_pkg::ROW_W'(tcce_pkg::NUM_ROWS));
        n_item.publish  = i_last && (i_req_type == tcce_pkg::REQ_CHAR);
        n_item.op       = tcce_pkg::OP_NOP;
        unique case (i_req_type)
            tcce_pkg::REQ_CHAR: begin
                unique case (i_char_code)
                    tcce_pkg::CH_NUL: n_item.op = tcce_pkg::OP_NOP;
                    tcce_pkg::CH_BS:  n_item.op = tcce_pkg::OP_BS;
                    tcce_pkg::CH_TAB: n_item.op = tcce_pkg::OP_TAB;
                    tcce_pkg::CH_NL:  n_item.op = tcce_pkg::OP_NEWLINE;
                    tcce_pkg::CH_CR:  n_item.op = tcce_pkg::OP_CR;
                    default:          n_item.op = tcce_pkg::OP_PUT;
                endcase
            end
            tcce_pkg::REQ_MOVE:    n_item.op = tcce_pkg::OP_MOVE;
            tcce_pkg::REQ_RESTORE: n_item.op = tcce_pkg::OP_RESTORE;
            tcce_pkg::REQ_CLEAR:   n_item.op = tcce_pkg::OP_CLEAR;
            tcce_pkg::REQ_READ:    n_item.op = tcce_pkg::OP_READ;
            default:               n_item.op = tcce_pkg::OP_NOP;
        endcase
    end

    // Holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

/* rtl/tcce_fifo.sv */
`timescale 1ns / 1ps

// Short queue of decoded items between front and back
module tcce_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tcce_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output tcce_pkg::t_item o_item,
    input  logic            i_pop
);

    localparam int PTR_W = $clog2(tcce_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(tcce_pkg::FIFO_DEPTH + 1);

    tcce_pkg::t_item   r_mem [tcce_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != CNT_W'(tcce_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rptr];

    // Pointers wrap at the depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(tcce_pkg::FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(tcce_pkg::FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

/* rtl/tcce_back.sv */
`timescale 1ns / 1ps
`include "text_console_char_engine_defines.svh"

// Execution unit: cursor state, screen store, row blanking and clear sweeps
module tcce_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tcce_pkg::CHAR_W-1:0] i_cfg_wdata,
    input  logic                        i_item_valid,
    input  tcce_pkg::t_item             i_item,
    output logic                        o_item_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [39:0]                 o_out_data
);

    localparam int COL_W  = tcce_pkg::COL_W;
    localparam int ROW_W  = tcce_pkg::ROW_W;
    localparam int ADDR_W = tcce_pkg::ADDR_W;
    localparam int IDX_W  = tcce_pkg::IDX_W;
    localparam int PROD_W = ROW_W + COL_W;

    // Physical store address of a screen-relative cell
    function automatic logic [ADDR_W-1:0] cell_addr(
        input logic [ROW_W-1:0] top,
        input logic [COL_W-1:0] c,
        input logic [ROW_W-1:0] r
    );
        logic [ROW_W:0]  phys;
        logic [PROD_W:0] prod;
        phys = {1'b0, top} + {1'b0, r};
        if (phys >= (ROW_W+1)'(tcce_pkg::NUM_ROWS)) begin
            phys = phys - (ROW_W+1)'(tcce_pkg::NUM_ROWS);
        end
        prod = (PROD_W+1)'(phys[ROW_W-1:0]) * (PROD_W+1)'(tcce_pkg::NUM_COLUMNS)
               + (PROD_W+1)'(c);
        return ADDR_W'(prod);
    endfunction

    tcce_pkg::t_back_state r_state, n_state;

    logic [COL_W-1:0]           r_col, n_col;
    logic [ROW_W-1:0]           r_row, n_row;
    logic [COL_W-1:0]           r_scol, n_scol;
    logic [ROW_W-1:0]           r_srow, n_srow;
    logic [ROW_W-1:0]           r_top, n_top;
    logic [IDX_W-1:0]           r_pub, n_pub;
    logic [tcce_pkg::CHAR_W-1:0] r_attr;
    logic [ADDR_W-1:0]          r_sweep_addr;
    logic [ADDR_W-1:0]          r_sweep_last;
    logic [tcce_pkg::CELL_W-1:0] r_sweep_data;
    logic                       r_out_valid;
    logic [39:0]                r_out_data;
    logic                       r_rd_ok;

    logic                        pop;
    logic                        lf, scroll, clr, rd_req;
    logic                        wr_en;
    logic [COL_W-1:0]            wr_col;
    logic [tcce_pkg::CELL_W-1:0] wr_data;
    logic [COL_W:0]              stop, wrap_col;
    logic [PROD_W-1:0]           pub_prod;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [tcce_pkg::CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [tcce_pkg::CELL_W-1:0] ram_rdata;

    // Take an item only when the result register has room for its result
    assign pop        = (r_state == tcce_pkg::ST_IDLE) && i_item_valid
                        && (!r_out_valid || i_out_ready);
    assign o_item_pop = pop;

    // Tab target and its wrap past the last column
    always_comb begin
        stop     = tcce_pkg::tab_stop(r_col);
        wrap_col = stop - (COL_W+1)'(tcce_pkg::NUM_COLUMNS);
        if (wrap_col >= (COL_W+1)'(tcce_pkg::NUM_COLUMNS)) begin
            wrap_col = wrap_col - (COL_W+1)'(tcce_pkg::NUM_COLUMNS);
        end
    end

    // Execute the item at the head of the queue
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_scol  = r_scol;
        n_srow  = r_srow;
        n_top   = r_top;
        lf      = 1'b0;
        clr     = 1'b0;
        rd_req  = 1'b0;
        wr_en   = 1'b0;
        wr_col  = r_col;
        wr_data = {r_attr, i_item.code};
        unique case (i_item.op)
            tcce_pkg::OP_PUT: begin
                wr_en = 1'b1;
                if (r_col == COL_W'(tcce_pkg::NUM_COLUMNS - 1)) begin
                    n_col = '0;
                    lf    = 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            tcce_pkg::OP_NEWLINE: begin
                n_col = '0;
                lf    = 1'b1;
            end
            tcce_pkg::OP_CR: begin
                n_col = '0;
            end
            tcce_pkg::OP_BS: begin
                if (r_col != '0) begin
                    n_col   = r_col - 1'b1;
                    wr_en   = 1'b1;
                    wr_col  = r_col - 1'b1;
                    wr_data = tcce_pkg::BLANK_SCROLL;
                end
            end
            tcce_pkg::OP_TAB: begin
                if (stop >= (COL_W+1)'(tcce_pkg::NUM_COLUMNS)) begin
                    n_col = wrap_col[COL_W-1:0];
                    lf    = 1'b1;
                end else begin
                    n_col = stop[COL_W-1:0];
                end
            end
            tcce_pkg::OP_MOVE: begin
                n_scol = r_col;
                n_srow = r_row;
                if (i_item.in_range) begin
                    n_col = i_item.col;
                    n_row = i_item.row;
                end
            end
            tcce_pkg::OP_RESTORE: begin
                n_col = r_scol;
                n_row = r_srow;
            end
            tcce_pkg::OP_CLEAR: begin
                clr   = 1'b1;
                n_top = '0;
                n_col = '0;
                n_row = '0;
            end
            tcce_pkg::OP_READ: begin
                rd_req = 1'b1;
            end
            default: begin
            end
        endcase

        // Line feed: step down, or scroll by rotating the top row
        scroll = lf && (r_row == ROW_W'(tcce_pkg::NUM_ROWS - 1));
        if (lf && !scroll) begin
            n_row = r_row + 1'b1;
        end
        if (scroll) begin
            n_top = (r_top == ROW_W'(tcce_pkg::NUM_ROWS - 1)) ? '0 : r_top + 1'b1;
        end

        // Published hardware cursor
        pub_prod = PROD_W'(n_row) * PROD_W'(tcce_pkg::NUM_COLUMNS) + PROD_W'(n_col);
        n_pub    = i_item.publish ? IDX_W'(pub_prod) : r_pub;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcce_pkg::ST_SWEEP: begin
                if (r_sweep_addr == r_sweep_last) begin
                    n_state = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_IDLE: begin
                if (pop) begin
                    if (scroll || clr) begin
                        n_state = tcce_pkg::ST_SWEEP;
                    end else if (rd_req) begin
                        n_state = tcce_pkg::ST_READ;
                    end
                end
            end
            tcce_pkg::ST_READ: begin
                n_state = tcce_pkg::ST_IDLE;
            end
            default: n_state = tcce_pkg::ST_IDLE;
        endcase
    end

    // Store port control
    always_comb begin
        ram_raddr = cell_addr(r_top, i_item.col, i_item.row);
        ram_we    = 1'b0;
        ram_waddr = cell_addr(r_top, wr_col, r_row);
        ram_wdata = wr_data;
        unique case (r_state)
            tcce_pkg::ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep_addr;
                ram_wdata = r_sweep_data;
            end
            tcce_pkg::ST_IDLE: begin
                ram_we = pop && wr_en;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // State, cursor and sweep registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcce_pkg::ST_SWEEP;
            r_col        <= '0;
            r_row        <= '0;
            r_scol       <= '0;
            r_srow       <= '0;
            r_top        <= '0;
            r_pub        <= '0;
            r_attr       <= tcce_pkg::ATTR_RESET;
            r_sweep_addr <= '0;
            r_sweep_last <= ADDR_W'(tcce_pkg::CELLS - 1);
            r_sweep_data <= tcce_pkg::BLANK_CLEAR;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (r_state == tcce_pkg::ST_SWEEP) begin
                r_sweep_addr <= r_sweep_addr + 1'b1;
            end
            if (pop) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_scol <= n_scol;
                r_srow <= n_srow;
                r_top  <= n_top;
                r_pub  <= n_pub;
                if (clr) begin
                    r_sweep_addr <= '0;
                    r_sweep_last <= ADDR_W'(tcce_pkg::CELLS - 1);
                    r_sweep_data <= tcce_pkg::BLANK_CLEAR;
                end else begin
                    r_sweep_addr <= cell_addr(r_top, '0, '0);
                    r_sweep_last <= cell_addr(r_top, COL_W'(tcce_pkg::NUM_COLUMNS - 1), '0);
                    r_sweep_data <= tcce_pkg::BLANK_SCROLL;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((pop && !rd_req) || (r_state == tcce_pkg::ST_READ)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_ok <= i_item.in_range;
        end
        if (pop && !rd_req) begin
            r_out_data <= {scroll, 8'h00, 8'h00, n_pub, n_row, n_col};
        end else if (r_state == tcce_pkg::ST_READ) begin
            r_out_data <= {1'b0,
                           r_rd_ok ? ram_rdata[15:8] : 8'h00,
                           r_rd_ok ? ram_rdata[7:0] : 8'h00,
                           r_pub, r_row, r_col};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Checks
    `TCCE_ASSERT_ALWAYS(a_cursor_range, i_clk, i_rst_n, (r_col < COL_W'(tcce_pkg::NUM_COLUMNS)) && (r_row < ROW_W'(tcce_pkg::NUM_ROWS)))
    `TCCE_ASSERT_ALWAYS(a_top_range, i_clk, i_rst_n, r_top < ROW_W'(tcce_pkg::NUM_ROWS))
    `TCCE_ASSERT_IMP(a_sweep_in_store, i_clk, i_rst_n, r_state == tcce_pkg::ST_SWEEP, (r_sweep_addr <= r_sweep_last) && (r_sweep_last < ADDR_W'(tcce_pkg::CELLS)))
    `TCCE_ASSERT_NEXT(a_read_result, i_clk, i_rst_n, r_state == tcce_pkg::ST_READ, r_out_valid && (r_state == tcce_pkg::ST_IDLE))

endmodule

/* rtl/text_console_char_engine.sv */
`timescale 1ns / 1ps

// Text console engine: screen store of character/attribute cells plus a cursor.
// Input stream (s_axis_*): one transaction per request; tuser carries the
// request kind, tlast marks the last character of a write. Output stream
// (m_axis_*): exactly one result transaction per request, in order.
// Configuration: i_cfg_we writes the print attribute from i_cfg_wdata; write
// it only while no request is in flight.
// Throughput: one request per cycle for printing and cursor moves, as the back end
// executes one queued request per cycle while the receiver keeps taking results; a
// cell read holds it in its read state. A scroll stalls the back end for one row to
// blank the new bottom row; a clear stalls it for the whole store (CELLS cells).
// Reset: the store is swept to 0x0F20; requests are queued during the sweep and
// executed after it. A stalled receiver holds the result register; the input
// keeps taking requests until the two-entry queue and the input stage are full.
module text_console_char_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // char_code[7:0], col[14:8], row[19:15], zero[23:20]
    input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // cursor_col[6:0], cursor_row[11:7],
                                       // hw_cursor_index[22:12], cell_char[30:23],
                                       // cell_attr[38:31], scrolled[39]
);

    logic            front_valid;
    tcce_pkg::t_item front_item;
    logic            fifo_ready;
    logic            fifo_valid;
    tcce_pkg::t_item fifo_item;
    logic            back_pop;

    // Decode stage
    tcce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_char_code  (s_axis_tdata[7:0]),
        .i_col        (s_axis_tdata[14:8]),
        .i_row        (s_axis_tdata[19:15]),
        .i_last       (s_axis_tlast),
        .o_item_valid (front_valid),
        .o_item       (front_item),
        .i_item_ready (fifo_ready)
    );

    // Decoupling queue
    tcce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_ready (fifo_ready),
        .o_valid (fifo_valid),
        .o_item  (fifo_item),
        .i_pop   (back_pop)
    );

    // Execution
    tcce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_item_valid (fifo_valid),
        .i_item       (fifo_item),
        .o_item_pop   (back_pop),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata)
    );

endmodule

/* sim/text_console_char_engine_tb.sv */
`timescale 1ns / 1ps

module text_console_char_engine_tb;
    import tcce_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 112;
    localparam int MAX_CLEARS  = 8;

    // Request codes the block does not define; it must just report the cursor
    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_READ + 3'd1;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAR_W-1:0] code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              last;
    } console_req_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [IDX_W-1:0]  idx;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] attr;
        logic              scrolled;
    } console_view_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;  // char_code[7:0], col[14:8], row[19:15], zero[23:20]
    logic [2:0]  s_axis_tuser  = '0;  // req_type[2:0]
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // cursor_col[6:0], cursor_row[11:7],
                                      // hw_cursor_index[22:12], cell_char[30:23],
                                      // cell_attr[38:31], scrolled[39]

    text_console_char_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow console state
    logic [CELL_W-1:0] screen_cells [CELLS];
    int                pred_col       = 0;
    int                pred_row       = 0;
    int                saved_col      = 0;
    int                saved_row      = 0;
    int                pred_top       = 0;
    logic [IDX_W-1:0]  pred_published = '0;
    logic [7:0]        pred_attr      = ATTR_RESET;

    console_req_t  console_pending  [$];
    console_view_t console_expected [$];
    console_req_t  in_flight;
    bit            steady_flow = 1'b0;
    int            fail_count  = 0;
    int            cycle_count = 0;

    // Stimulus generator state
    int anchor_col = 0;
    int anchor_row = 0;
    int gen_clears = 0;

    function automatic int screen_addr(int c, int r);
        return ((pred_top + r) % NUM_ROWS) * NUM_COLUMNS + c;
    endfunction

    // Line feed; on the bottom row the oldest physical row becomes the new blank bottom row
    function automatic bit line_feed_scrolls();
        int base;
        if (pred_row + 1 < NUM_ROWS) begin
            pred_row++;
            return 1'b0;
        end
        base = pred_top * NUM_COLUMNS;
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            screen_cells[base + c] = BLANK_SCROLL;
        end
        pred_top = (pred_top + 1) % NUM_ROWS;
        pred_row = NUM_ROWS - 1;
        return 1'b1;
    endfunction

    // Applies one request to the shadow state and returns the result it should produce
    function automatic console_view_t console_apply(console_req_t rq);
        console_view_t res;
        logic [CELL_W-1:0] word;
        bit scr;
        scr = 1'b0;
        res = '0;
        case (rq.kind)
            REQ_CHAR: begin
                case (rq.code)
                    CH_NL: begin
                        pred_col = 0;
                        scr = line_feed_scrolls();
                    end
                    CH_CR: pred_col = 0;
                    CH_BS: begin
                        if (pred_col > 0) begin
                            pred_col--;
                            screen_cells[screen_addr(pred_col, pred_row)] = BLANK_SCROLL;
                        end
                    end
                    CH_TAB: begin
                        pred_col = (pred_col / TAB_STEP + 1) * TAB_STEP;
                        if (pred_col >= NUM_COLUMNS) begin
                            pred_col = (pred_col - NUM_COLUMNS) % NUM_COLUMNS;
                            scr = line_feed_scrolls();
                        end
                    end
                    CH_NUL: ;
                    default: begin
                        screen_cells[screen_addr(pred_col, pred_row)] = {pred_attr, rq.code};
                        pred_col++;
                        if (pred_col >= NUM_COLUMNS) begin
                            pred_col = 0;
                            scr = line_feed_scrolls();
                        end
                    end
                endcase
                if (rq.last) begin
                    pred_published = IDX_W'(pred_row * NUM_COLUMNS + pred_col);
                end
            end
            REQ_MOVE: begin
                saved_col = pred_col;
                saved_row = pred_row;
                if (rq.col < NUM_COLUMNS && rq.row < NUM_ROWS) begin
                    pred_col = rq.col;
                    pred_row = rq.row;
                end
            end
            REQ_RESTORE: begin
                pred_col = saved_col;
                pred_row = saved_row;
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen_cells[i] = BLANK_CLEAR;
                end
                pred_top = 0;
                pred_col = 0;
                pred_row = 0;
            end
            REQ_READ: begin
                if (rq.col < NUM_COLUMNS && rq.row < NUM_ROWS) begin
                    word = screen_cells[screen_addr(rq.col, rq.row)];
                    res.ch = word[7:0];
                    res.attr = word[15:8];
                end
            end
            default: ;
        endcase
        res.col = COL_W'(pred_col);
        res.row = ROW_W'(pred_row);
        res.idx = pred_published;
        res.scrolled = scr;
        return res;
    endfunction

    // Redraws col/row until the position falls outside the screen
    function automatic console_req_t off_screen(console_req_t rq);
        while (rq.col < NUM_COLUMNS && rq.row < NUM_ROWS) begin
            rq.col = 7'($urandom_range(127));
            rq.row = 5'($urandom_range(31));
        end
        return rq;
    endfunction

    // Mostly printing and cursor work, reads biased toward recently touched rows
    function automatic console_req_t random_request();
        console_req_t rq;
        int roll;
        int pick;
        rq.kind = REQ_CHAR;
        rq.code = 8'($urandom_range(255));
        rq.col  = 7'($urandom_range(127));
        rq.row  = 5'($urandom_range(31));
        rq.last = 1'($urandom_range(1));
        roll = $urandom_range(999);
        pick = $urandom_range(99);
        if (roll < 560) begin
            if (pick < 45) begin
                rq.code = 8'($urandom_range(8'h7E, 8'h20));
            end else if (pick < 55) begin
                rq.code = 8'($urandom_range(255, 128));
            end else if (pick < 68) begin
                rq.code = CH_NL;
            end else if (pick < 74) begin
                rq.code = CH_CR;
            end else if (pick < 83) begin
                rq.code = CH_BS;
            end else if (pick < 92) begin
                rq.code = CH_TAB;
            end else if (pick < 95) begin
                rq.code = CH_NUL;
            end
        end else if (roll < 680) begin
            rq.kind = REQ_MOVE;
            if (pick < 70) begin
                rq.col = 7'($urandom_range(NUM_COLUMNS - 1));
                rq.row = (pick < 28) ? 5'(NUM_ROWS - 1) : 5'($urandom_range(NUM_ROWS - 1));
                anchor_col = rq.col;
                anchor_row = rq.row;
            end else begin
                rq = off_screen(rq);
            end
        end else if (roll < 720) begin
            rq.kind = REQ_RESTORE;
        end else if (roll < 735) begin
            rq.kind = (gen_clears < MAX_CLEARS) ? REQ_CLEAR : REQ_RESTORE;
            if (rq.kind == REQ_CLEAR) begin
                gen_clears++;
            end
        end else if (roll < 960) begin
            rq.kind = REQ_READ;
            if (pick < 55) begin
                rq.col = 7'((anchor_col + $urandom_range(15)) % NUM_COLUMNS);
                rq.row = 5'(anchor_row);
            end else if (pick < 85) begin
                rq.col = 7'($urandom_range(NUM_COLUMNS - 1));
                rq.row = 5'($urandom_range(NUM_ROWS - 1));
            end else begin
                rq = off_screen(rq);
            end
        end else begin
            rq.kind = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
        end
        return rq;
    endfunction

    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] code,
                            input int col, input int row, input bit last);
        console_req_t rq;
        rq.kind = kind;
        rq.code = code;
        rq.col  = 7'(col);
        rq.row  = 5'(row);
        rq.last = last;
        console_pending.push_back(rq);
    endtask

    task automatic write_attr(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pred_attr = value;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (console_pending.size() != 0 || s_axis_tvalid || console_expected.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Request driver: predicts on each accepted transaction, then loads the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                console_expected.push_back(console_apply(in_flight));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (console_pending.size() != 0 && (steady_flow || $urandom_range(99) >= 25)) begin
                    in_flight = console_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'b0, in_flight.row, in_flight.col, in_flight.code};
                    s_axis_tuser  <= in_flight.kind;
                    s_axis_tlast  <= in_flight.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin : result_check
        console_view_t got;
        console_view_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.col      = m_axis_tdata[6:0];
                got.row      = m_axis_tdata[11:7];
                got.idx      = m_axis_tdata[22:12];
                got.ch       = m_axis_tdata[30:23];
                got.attr     = m_axis_tdata[38:31];
                got.scrolled = m_axis_tdata[39];
                if (console_expected.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    fail_count++;
                end else begin
                    want = console_expected.pop_front();
                    check_field("cursor_col", want.col, got.col);
                    check_field("cursor_row", want.row, got.row);
                    check_field("hw_cursor_index", want.idx, got.idx);
                    check_field("cell_char", want.ch, got.ch);
                    check_field("cell_attr", want.attr, got.attr);
                    check_field("scrolled", want.scrolled, got.scrolled);
                end
            end
            m_axis_tready <= steady_flow || ($urandom_range(99) >= 25);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_char_engine test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] attr_plan [4];
        attr_plan[0] = 8'hFF;
        attr_plan[1] = 8'h00;
        attr_plan[2] = 8'($urandom_range(255));
        attr_plan[3] = 8'($urandom_range(255));
        for (int i = 0; i < CELLS; i++) begin
            screen_cells[i] = BLANK_CLEAR;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset attribute, control codes, wrap, scrolls, range checks
        push_req(REQ_READ, CH_NUL, 0, 0, 1'b0);
        push_req(REQ_CHAR, 8'h41, 0, 0, 1'b1);
        push_req(REQ_READ, CH_NUL, 0, 0, 1'b0);
        push_req(REQ_CHAR, CH_BS, 0, 0, 1'b1);
        push_req(REQ_READ, CH_NUL, 0, 0, 1'b0);
        push_req(REQ_CHAR, CH_BS, 0, 0, 1'b0);          // already at column 0
        push_req(REQ_CHAR, CH_TAB, 0, 0, 1'b1);
        push_req(REQ_CHAR, CH_CR, 0, 0, 1'b0);
        push_req(REQ_CHAR, CH_NUL, 0, 0, 1'b1);
        push_req(REQ_MOVE, CH_NUL, NUM_COLUMNS - 1, NUM_ROWS - 1, 1'b1);
        push_req(REQ_CHAR, 8'hFF, 0, 0, 1'b1);          // wrap on bottom row scrolls
        push_req(REQ_READ, CH_NUL, NUM_COLUMNS - 1, NUM_ROWS - 2, 1'b0);
        push_req(REQ_READ, 8'hFF, 127, 31, 1'b1);       // off screen reads zero
        push_req(REQ_MOVE, CH_NUL, NUM_COLUMNS, 3, 1'b0);
        push_req(REQ_MOVE, CH_NUL, 3, NUM_ROWS, 1'b0);
        push_req(REQ_RESTORE, CH_NUL, 0, 0, 1'b0);
        push_req(REQ_MOVE, CH_NUL, NUM_COLUMNS - 5, NUM_ROWS - 1, 1'b0);
        push_req(REQ_CHAR, CH_TAB, 0, 0, 1'b1);         // tab past last column
        push_req(REQ_CHAR, CH_NL, 0, 0, 1'b1);
        for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++) begin
            push_req(3'(k), 8'hAA, 85, 20, 1'b1);
        end
        push_req(REQ_CLEAR, CH_NUL, 0, 0, 1'b1);
        push_req(REQ_READ, CH_NUL, NUM_COLUMNS - 1, NUM_ROWS - 1, 1'b0);
        wait_idle();

        // Random phases, attribute rewritten between them; second phase runs without stalls
        for (int p = 0; p < 4; p++) begin
            repeat (8) @(posedge i_clk);
            write_attr(attr_plan[p]);
            steady_flow = (p == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                console_pending.push_back(random_request());
            end
            wait_idle();
        end
        steady_flow = 1'b0;

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && console_expected.size() == 0) begin
            $display("text_console_char_engine test passed");
        end else begin
            $display("text_console_char_engine test failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_front.sv
rtl/tcce_fifo.sv
rtl/tcce_back.sv
rtl/text_console_char_engine.sv
sim/text_console_char_engine_tb.sv
